// ===== hw/rtl/uerf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uerf_pkg
// Types and constants shared by the echo range filter controller and datapath.
// ----------------------------------------------------------------------------
package uerf_pkg;

   // field widths
   localparam int STAMP_W  = 16;
   localparam int SAMPLE_W = 8;
   localparam int DIST_W   = 9;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ECHO    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MODE = 2'd1;

   // register reset values
   localparam logic [STAMP_W-1:0] MAX_ECHO_RESET    = 16'd464;
   localparam logic               FILTER_MODE_RESET = 1'b1;

   // filter modes and result kinds
   localparam logic MODE_MEDIAN  = 1'b0;
   localparam logic MODE_TRIMMED = 1'b1;
   localparam logic KIND_RAW     = 1'b0;
   localparam logic KIND_FILTER  = 1'b1;

   // ticks to cm: floor(w * 343 / 625), saturating at 255
   localparam int QUO_W = 8;
   localparam int REM_W = 18;
   localparam int DIV_W = 10;
   localparam int SCALE_IN_W = 9;
   localparam logic [SCALE_IN_W-1:0] CM_SCALE   = 9'd343;
   localparam logic [DIV_W-1:0]      CM_DIVISOR = 10'd625;
   // exact divide by 625 for products below 2^REM_W: (p * CM_RECIP) >> CM_SHIFT
   localparam int CM_RECIP_W = 19;
   localparam int CM_SHIFT   = 28;
   localparam logic [CM_RECIP_W-1:0] CM_RECIP = 19'd429497;
   // smallest width whose sample would pass 255 cm
   localparam logic [STAMP_W-1:0]    SAT_TICKS  = 16'd467;
   localparam logic [SAMPLE_W-1:0]   SAMPLE_MAX = 8'd255;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_CM,
      ST_DONE_RAW,
      ST_WALK,
      ST_TRIM,
      ST_DIV_MEAN,
      ST_DONE_FILT
   } uerf_state_type;

   typedef struct packed {
      logic load_start;
      logic load_width;
      logic calc_product;
      logic div_step;
      logic walk_init;
      logic walk_step;
      logic trim_calc;
      logic load_raw;
      logic load_filt;
   } uerf_cmd_type;

   typedef struct packed {
      logic awaiting_end;
      logic filter_mode;
      logic walk_last;
   } uerf_status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ultrasonic_echo_range_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_range_filter
// Echo width to distance conversion with a ring window and a trimmed mean or
// median filter read out by query items.
// ----------------------------------------------------------------------------
//  channel  ports                          direction  moves
//  req      req_valid/ready, op, stamp     in         capture edge or query
//  rsp      rsp_valid/ready, kind, dist    out        raw sample or filtered
//  csr      csr_valid/ready, index, wdata  in         register write
//
//  echo start is a single step; echo end steps through width, multiply,
//  reciprocal multiply and result load; a query walks the window one entry
//  per cycle, and a trimmed mean query adds trim and divide before its load.
//  reset is synchronous; the window clears to zero at once.
//  a waiting result holds only the finishing step; new items are taken
//  while the result register is still full.
// ----------------------------------------------------------------------------
module ultrasonic_echo_range_filter
   import uerf_pkg::*;
#(
   parameter int WINDOW = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_op,
   input  wire logic [STAMP_W-1:0]   req_capture_stamp,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_kind,
   output logic [DIST_W-1:0]         rsp_distance,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [STAMP_W-1:0]   csr_wdata
);

   uerf_cmd_type    cmd;
   uerf_status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // sequencer
   uerf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   uerf_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_capture_stamp (req_capture_stamp),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_kind          (rsp_kind),
      .rsp_distance      (rsp_distance)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/uerf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uerf_ctrl
// Sequencer for capture and query items, plus the result valid flag.
// ----------------------------------------------------------------------------
module uerf_ctrl
   import uerf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic            req_op,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire uerf_status_type status,
   output uerf_cmd_type         cmd
);

   uerf_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   // state and result flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op) begin
                  cmd.walk_init = 1'b1;
                  state_in      = ST_WALK;
               end else if (!status.awaiting_end) begin
                  cmd.load_start = 1'b1;
               end else begin
                  cmd.load_width = 1'b1;
                  state_in       = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.calc_product = 1'b1;
            state_in         = ST_DIV_CM;
         end
         ST_DIV_CM: begin
            cmd.div_step = 1'b1;
            state_in     = ST_DONE_RAW;
         end
         ST_DONE_RAW: begin
            if (rsp_free) begin
               cmd.load_raw = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = (status.filter_mode == MODE_TRIMMED) ? ST_TRIM : ST_DONE_FILT;
            end
         end
         ST_TRIM: begin
            cmd.trim_calc = 1'b1;
            state_in      = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            cmd.div_step = 1'b1;
            state_in     = ST_DONE_FILT;
         end
         ST_DONE_FILT: begin
            if (rsp_free) begin
               cmd.load_filt = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/uerf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uerf_dp
// Datapath: config registers, echo width, reciprocal multiply divides, sample
// ring and the window walk for trimmed mean and median selection.
// ----------------------------------------------------------------------------
module uerf_dp
   import uerf_pkg::*;
#(
   parameter int WINDOW = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire uerf_cmd_type         cmd,
   output uerf_status_type           status,
   input  wire logic [STAMP_W-1:0]   req_capture_stamp,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [STAMP_W-1:0]   csr_wdata,
   output logic                      rsp_kind,
   output logic [DIST_W-1:0]         rsp_distance
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int SUM_W = $clog2(WINDOW * 255 + 1);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(WINDOW - 1);
   localparam logic [IDX_W-1:0] MED_LO_IDX = IDX_W'(WINDOW / 2 - 1);
   localparam logic [IDX_W-1:0] MED_HI_IDX = IDX_W'(WINDOW / 2);
   // divide by WINDOW-2 as a rounded-up reciprocal, exact below 2^SUM_W
   localparam int MEAN_SHIFT   = SUM_W + 4;
   localparam int MEAN_RECIP_W = MEAN_SHIFT + 1;
   localparam int MEAN_PROD_W  = SUM_W + MEAN_RECIP_W;
   localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP =
      MEAN_RECIP_W'(((1 << MEAN_SHIFT) + WINDOW - 3) / (WINDOW - 2));
   localparam int CM_PROD_W = REM_W + CM_RECIP_W;

   logic [STAMP_W-1:0]  max_echo_ff;
   logic                mode_ff;
   logic                awaiting_ff;
   logic [STAMP_W-1:0]  start_ff;
   logic [SAMPLE_W-1:0] win_ff [WINDOW];
   logic [IDX_W-1:0]    slot_ff;

   logic [STAMP_W-1:0]     width_ff, width_in;
   logic [STAMP_W-1:0]     diff;
   logic                   sat_ff;
   logic [REM_W-1:0]       rem_ff;
   logic [QUO_W-1:0]       quo_ff, quo_in;
   logic                   by_window_ff;
   logic [CM_PROD_W-1:0]   cm_prod;
   logic [MEAN_PROD_W-1:0] mean_prod;

   logic [IDX_W-1:0]    idx_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [SAMPLE_W-1:0] hi_ff, lo_ff, med_lo_ff, med_hi_ff;
   logic [SAMPLE_W-1:0] cur;
   logic [IDX_W-1:0]    rank;
   logic [SAMPLE_W-1:0] cm;

   // control state: config, echo edge tracking, sample ring
   always_ff @(posedge clock) begin
      if (reset) begin
         max_echo_ff <= MAX_ECHO_RESET;
         mode_ff     <= FILTER_MODE_RESET;
         awaiting_ff <= 1'b0;
         start_ff    <= '0;
         slot_ff     <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_MAX_ECHO:    max_echo_ff <= csr_wdata;
               CSR_FILTER_MODE: mode_ff     <= csr_wdata[0];
               default: ;
            endcase
         end
         if (cmd.load_start) begin
            start_ff    <= req_capture_stamp;
            awaiting_ff <= 1'b1;
         end
         if (cmd.load_width) begin
            awaiting_ff <= 1'b0;
         end
         if (cmd.load_raw) begin
            win_ff[slot_ff] <= cm;
            slot_ff         <= (slot_ff == LAST_IDX) ? '0 : slot_ff + 1'b1;
         end
      end
   end

   // echo width, wrapped and clamped
   assign diff     = req_capture_stamp - start_ff;
   assign width_in = (diff > max_echo_ff) ? max_echo_ff : diff;

   // divide by constant: multiply by the cm or mean reciprocal, keep the upper bits
   assign cm_prod   = CM_PROD_W'(rem_ff) * CM_PROD_W'(CM_RECIP);
   assign mean_prod = MEAN_PROD_W'(rem_ff[SUM_W-1:0]) * MEAN_PROD_W'(MEAN_RECIP);
   assign quo_in    = by_window_ff ? mean_prod[MEAN_SHIFT +: QUO_W]
                                   : cm_prod[CM_SHIFT +: QUO_W];

   // current window entry and its stable rank among all entries
   assign cur = win_ff[idx_ff];

   always_comb begin
      rank = '0;
      for (int j = 0; j < WINDOW; j++) begin
         if ((win_ff[j] < cur) || ((win_ff[j] == cur) && (IDX_W'(j) < idx_ff))) begin
            rank = rank + 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cmd.load_width) begin
         width_ff <= width_in;
      end
      if (cmd.calc_product) begin
         sat_ff       <= (width_ff >= SAT_TICKS);
         rem_ff       <= (width_ff >= SAT_TICKS) ? '0
                         : REM_W'(width_ff[SCALE_IN_W-1:0]) * REM_W'(CM_SCALE);
         by_window_ff <= 1'b0;
      end else if (cmd.trim_calc) begin
         rem_ff       <= REM_W'(sum_ff - SUM_W'(hi_ff) - SUM_W'(lo_ff));
         by_window_ff <= 1'b1;
      end
      if (cmd.div_step) begin
         quo_ff <= quo_in;
      end
      if (cmd.walk_init) begin
         idx_ff <= '0;
         sum_ff <= '0;
         hi_ff  <= '0;
         lo_ff  <= SAMPLE_MAX;
      end else if (cmd.walk_step) begin
         idx_ff <= idx_ff + 1'b1;
         sum_ff <= sum_ff + SUM_W'(cur);
         if (cur > hi_ff) hi_ff <= cur;
         if (cur < lo_ff) lo_ff <= cur;
         if (rank == MED_LO_IDX) med_lo_ff <= cur;
         if (rank == MED_HI_IDX) med_hi_ff <= cur;
      end
   end

   // raw sample from the divide
   assign cm = sat_ff ? SAMPLE_MAX : quo_ff;

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_raw) begin
         rsp_kind     <= KIND_RAW;
         rsp_distance <= DIST_W'(cm);
      end else if (cmd.load_filt) begin
         rsp_kind <= KIND_FILTER;
         if (mode_ff == MODE_TRIMMED) begin
            rsp_distance <= {quo_ff, 1'b0};
         end else begin
            rsp_distance <= DIST_W'(med_lo_ff) + DIST_W'(med_hi_ff);
         end
      end
   end

   assign status.awaiting_end = awaiting_ff;
   assign status.filter_mode  = mode_ff;
   assign status.walk_last    = (idx_ff == LAST_IDX);

endmodule
`default_nettype wire
